/* rtl/core/pmqd_pkg.sv */
// Package: shared constants and types for the priority message queue.
package pmqd_pkg;
    localparam int POOL_DEPTH   = 32;
    localparam int PRIO_LEVELS  = 32;
    localparam int NUM_SERVICES = 32;
    localparam int SLOT_W  = $clog2(POOL_DEPTH);
    localparam int LEVEL_W = $clog2(PRIO_LEVELS);
    localparam int CNT_W   = $clog2(POOL_DEPTH + 1);

    localparam logic [2:0] ST_QUEUED        = 3'd0;
    localparam logic [2:0] ST_POOL_EMPTY    = 3'd1;
    localparam logic [2:0] ST_DROP_SEND     = 3'd2;
    localparam logic [2:0] ST_DELIVERED     = 3'd3;
    localparam logic [2:0] ST_DROP_DISPATCH = 3'd4;
    localparam logic [2:0] ST_NONE          = 3'd5;

    localparam logic OP_SEND     = 1'b0;
    localparam logic OP_DISPATCH = 1'b1;

    // controller -> datapath
    typedef struct packed {
        logic load;      // capture input item
        logic rd;        // issue memory reads for the held item
        logic exec;      // apply update, build result
    } pmqd_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic dummy_ok;
    } pmqd_stat_t;

    typedef struct packed {
        logic [31:0] reply_handle;
        logic [31:0] msg_handle;
        logic [4:0]  prio;
        logic [4:0]  service_index;
        logic        op;
    } pmqd_item_t;

    typedef struct packed {
        logic [5:0]  free_slots;
        logic        any_pending;
        logic [31:0] out_reply;
        logic [31:0] out_msg;
        logic [4:0]  out_service;
        logic [2:0]  status;
    } pmqd_res_t;

    function automatic logic [LEVEL_W-1:0] lowest_set(input logic [PRIO_LEVELS-1:0] x);
        logic [LEVEL_W-1:0] n;
        n = '0;
        for (int i = PRIO_LEVELS - 1; i >= 0; i--)
            if (x[i])
                n = LEVEL_W'(i);
        return n;
    endfunction
endpackage

/* rtl/core/pmqd_ctrl.sv */
// Controller: sequences load, read and execute phases for one item.
module pmqd_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_fire,
    input  logic               out_busy,
    input  pmqd_pkg::pmqd_stat_t stat,
    output pmqd_pkg::pmqd_cmd_t  cmd,
    output logic               in_rdy
);
    import pmqd_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_READ = 2'd1;
    localparam logic [1:0] S_EXEC = 2'd2;

    logic [1:0] state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        cmd = '0;
        in_rdy = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_rdy = 1'b1;
                cmd.load = in_fire;
                if (in_fire)
                    state_next = S_READ;
            end
            S_READ:
            begin
                cmd.rd = 1'b1;
                state_next = S_EXEC;
            end
            S_EXEC:
            begin
                // wait until the output register is free
                if (!out_busy && stat.dummy_ok)
                begin
                    cmd.exec = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end
endmodule

/* rtl/core/pmqd_dp.sv */
// Datapath: slot pool memories, level lists, bitmap and result register.
module pmqd_dp (
    input  logic                clk,
    input  logic                rst_n,
    input  pmqd_pkg::pmqd_cmd_t cmd,
    input  pmqd_pkg::pmqd_item_t item,
    input  logic [31:0]         running_mask,
    output pmqd_pkg::pmqd_stat_t stat,
    output pmqd_pkg::pmqd_res_t res
);
    import pmqd_pkg::*;

    logic [SLOT_W-1:0]  slot_link  [POOL_DEPTH];
    logic [31:0]        slot_msg   [POOL_DEPTH];
    logic [31:0]        slot_reply [POOL_DEPTH];
    logic [4:0]         slot_service [POOL_DEPTH];
    logic [SLOT_W-1:0]  level_head [PRIO_LEVELS];
    logic [SLOT_W-1:0]  level_tail [PRIO_LEVELS];
    logic [POOL_DEPTH-1:0] link_vld_reg;   // unset: link reads as index+1

    pmqd_item_t            item_reg;
    logic [PRIO_LEVELS-1:0] nonempty_reg, nonempty_next;
    logic [SLOT_W-1:0]     free_head_reg, free_head_next;
    logic [CNT_W-1:0]      free_count_reg, free_count_next;

    // registered read results
    logic [LEVEL_W-1:0] lv_reg;
    logic [SLOT_W-1:0]  hd_reg, tl_reg, hlink_raw, flink_raw;
    logic               hlink_v, flink_v;
    logic [31:0]        rmsg_reg, rrep_reg;
    logic [4:0]         rsvc_reg;

    logic [LEVEL_W-1:0] lv_sel;
    logic [SLOT_W-1:0]  hd_sel;
    assign lv_sel = lowest_set(nonempty_reg);
    assign hd_sel = level_head[lv_sel];

    // item capture on load; read phase: level head/tail, head slot contents and free-list link
    always_ff @(posedge clk)
    begin
        if (cmd.load)
            item_reg <= item;
        if (cmd.rd)
        begin
            lv_reg    <= lv_sel;
            hd_reg    <= hd_sel;
            tl_reg    <= level_tail[lv_sel];
            rmsg_reg  <= slot_msg[hd_sel];
            rrep_reg  <= slot_reply[hd_sel];
            rsvc_reg  <= slot_service[hd_sel];
            hlink_raw <= slot_link[hd_sel];
            hlink_v   <= link_vld_reg[hd_sel];
            flink_raw <= slot_link[free_head_reg];
            flink_v   <= link_vld_reg[free_head_reg];
        end
    end

    logic [SLOT_W-1:0] hlink, flink;
    assign hlink = hlink_v ? hlink_raw : SLOT_W'(hd_reg + 1'b1);
    assign flink = flink_v ? flink_raw : SLOT_W'(free_head_reg + 1'b1);

    logic svc_run, pop_run, is_send, prio_ok, send_ok, any_lv, last;
    logic [LEVEL_W-1:0] sprio;
    assign is_send = (item_reg.op == OP_SEND);
    assign prio_ok = {27'd0, item_reg.prio} < 32'(PRIO_LEVELS);
    assign sprio   = LEVEL_W'(item_reg.prio);
    assign svc_run = ({27'd0, item_reg.service_index} < 32'(NUM_SERVICES))
                     && running_mask[item_reg.service_index];
    assign pop_run = ({27'd0, rsvc_reg} < 32'(NUM_SERVICES)) && running_mask[rsvc_reg];
    assign send_ok = prio_ok && (free_count_reg != '0) && svc_run;
    assign any_lv  = |nonempty_reg;
    assign last    = (hd_reg == tl_reg);

    pmqd_res_t res_c;
    always_comb
    begin
        nonempty_next   = nonempty_reg;
        free_head_next  = free_head_reg;
        free_count_next = free_count_reg;
        res_c = '0;
        if (is_send)
        begin
            res_c.out_service = item_reg.service_index;
            if (!prio_ok)
                res_c.status = ST_DROP_SEND;
            else if (free_count_reg == '0)
                res_c.status = ST_POOL_EMPTY;
            else if (!svc_run)
                res_c.status = ST_DROP_SEND;
            else
            begin
                res_c.status = ST_QUEUED;
                free_head_next  = flink;
                free_count_next = free_count_reg - 1'b1;
                nonempty_next[sprio] = 1'b1;
            end
        end
        else if (!any_lv)
            res_c.status = ST_NONE;
        else
        begin
            res_c.out_service = rsvc_reg;
            res_c.out_msg     = rmsg_reg;
            res_c.out_reply   = rrep_reg;
            res_c.status      = pop_run ? ST_DELIVERED : ST_DROP_DISPATCH;
            if (last)
                nonempty_next[lv_reg] = 1'b0;
            free_head_next = hd_reg;
            if (free_count_reg < CNT_W'(POOL_DEPTH))
                free_count_next = free_count_reg + 1'b1;
        end
        res_c.any_pending = |nonempty_next;
        res_c.free_slots  = 6'(free_count_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            nonempty_reg   <= '0;
            free_head_reg  <= '0;
            free_count_reg <= CNT_W'(POOL_DEPTH);
            link_vld_reg   <= '0;
        end
        else if (cmd.exec)
        begin
            nonempty_reg   <= nonempty_next;
            free_head_reg  <= free_head_next;
            free_count_reg <= free_count_next;
            if (is_send && send_ok && nonempty_reg[sprio])
                link_vld_reg[level_tail[sprio]] <= 1'b1;
            else if (!is_send && any_lv)
                link_vld_reg[hd_reg] <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.exec)
        begin
            res <= res_c;
            if (is_send && send_ok)
            begin
                slot_msg[free_head_reg]     <= item_reg.msg_handle;
                slot_reply[free_head_reg]   <= item_reg.reply_handle;
                slot_service[free_head_reg] <= item_reg.service_index;
                if (nonempty_reg[sprio])
                    slot_link[level_tail[sprio]] <= free_head_reg;
                else
                    level_head[sprio] <= free_head_reg;
                level_tail[sprio] <= free_head_reg;
            end
            else if (!is_send && any_lv)
            begin
                slot_link[hd_reg] <= free_head_reg;
                if (!last)
                    level_head[lv_reg] <= hlink;
            end
        end
    end

    assign stat.dummy_ok = 1'b1;
endmodule

/* rtl/core/priority_message_queue_dispatch_top.sv */
// Top level: strict-priority message queue with stream ports.
// Each input transfer is captured, then the tables are read, then the update is applied and
// the result registered once the output register is free; the next item is taken after that.
// A new item is taken while the previous result waits in the output register.
// rst_n clears all control state asynchronously; running_mask resets to all ones.
// No clearing pass: the free-list links carry per-slot valid bits.
module priority_message_queue_dispatch_top (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [79:0]  s_tdata,   // service_index, prio, msg_handle, reply_handle, pad
    input  logic         s_tuser,   // op
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [79:0]  m_tdata,   // status, out_service, out_msg, out_reply, any_pending,
                                    // free_slots, pad
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [31:0]  cfg_data
);
    import pmqd_pkg::*;

    pmqd_cmd_t  cmd;
    pmqd_stat_t stat;
    pmqd_item_t item;
    pmqd_res_t  res;
    logic [31:0] mask_reg;
    logic out_v_reg, in_rdy;

    assign cfg_ready = 1'b1;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            mask_reg <= '1;
        else if (cfg_valid)
            mask_reg <= cfg_data;
    end

    assign item.op            = s_tuser;
    assign item.service_index = s_tdata[4:0];
    assign item.prio          = s_tdata[9:5];
    assign item.msg_handle    = s_tdata[41:10];
    assign item.reply_handle  = s_tdata[73:42];
    assign s_tready = in_rdy;

    pmqd_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .in_fire(s_tvalid && in_rdy),
        .out_busy(out_v_reg && !m_tready), .stat(stat), .cmd(cmd), .in_rdy(in_rdy)
    );

    pmqd_dp u_dp (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .item(item),
        .running_mask(mask_reg), .stat(stat), .res(res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_v_reg <= 1'b0;
        else if (cmd.exec)
            out_v_reg <= 1'b1;
        else if (m_tready)
            out_v_reg <= 1'b0;
    end

    assign m_tvalid = out_v_reg;
    assign m_tdata  = {1'b0, res};
endmodule

/* rtl/core/pmqd_checker.sv */
// Checker: port-level assertions for the queue top level, with bind.
module pmqd_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [79:0] m_tdata
);
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");
    a_status: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[2:0] <= 3'd5)
        else $error("bad status code");
    a_free: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[78:73] <= 6'd32)
        else $error("free count out of range");
    a_gap: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("item taken back to back");
endmodule

bind priority_message_queue_dispatch_top pmqd_checker u_chk (
    .clk(clk), .rst_n(rst_n), .s_tvalid(s_tvalid), .s_tready(s_tready),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
);
